// File: src/stt_pkg.sv
// Shared types and constants for the session text tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stt_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Token kinds carried at token end
  localparam logic [1:0] TOK_TITLE0 = 2'd0;
  localparam logic [1:0] TOK_TITLE1 = 2'd1;
  localparam logic [1:0] TOK_KEY    = 2'd2;
  localparam logic [1:0] TOK_VALUE  = 2'd3;

  // Parse error codes
  localparam logic [1:0] ERR_BLANK_BEFORE = 2'd0;
  localparam logic [1:0] ERR_BAD_AFTER    = 2'd1;
  localparam logic [1:0] ERR_BLANK_LINE   = 2'd2;
  localparam logic [1:0] ERR_INCOMPLETE   = 2'd3;

  // Input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  // Characters of interest
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Default depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;

  // One result item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] tok;
    logic [1:0] err;
  } result_t;

  // Everything one input byte produces: one or two results
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } entry_t;

endpackage

// File: src/stt_front.sv
// Front end: accepts input items, runs the tokenizer state machine and
// packs the one or two results of an item, if any, into a queue entry. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_front
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_byte,
  input  logic       q_ready,
  output logic       push,
  output entry_t     push_entry
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_BEFORE  = 3'd1,
    ST_TITLE   = 3'd2,
    ST_AFTER   = 3'd3,
    ST_KEY     = 3'd4,
    ST_VALUE   = 3'd5,
    ST_NEWLINE = 3'd6,
    ST_SPACE   = 3'd7
  } state_t;

  state_t ps_r, ps_nxt;
  state_t rs_r, rs_nxt;
  logic   meq_r, meq_nxt;
  logic   tne_r, tne_nxt;
  logic   halted_r, halted_nxt;

  logic       acc;
  logic       ws;
  logic [7:0] mark;
  logic [1:0] nres;
  result_t    r0, r1;

  assign in_ready = q_ready;
  assign acc      = in_valid && in_ready;
  assign ws       = (in_byte <= CH_SPACE);
  assign mark     = meq_r ? CH_EQUALS : CH_DASH;

  // Next-state and result logic for one byte
  always_comb begin
    ps_nxt     = ps_r;
    rs_nxt     = rs_r;
    meq_nxt    = meq_r;
    tne_nxt    = tne_r;
    halted_nxt = halted_r;
    nres       = 2'd0;
    r0         = '0;
    r1         = '0;
    if (in_command == CMD_EOS) begin
      if (!halted_r) begin
        if (ps_r == ST_VALUE || rs_r == ST_VALUE) begin
          r0.kind = KIND_END;
          r0.tok  = TOK_VALUE;
          nres    = 2'd1;
        end else if (ps_r != ST_IDLE) begin
          r0.kind = KIND_ERROR;
          r0.err  = ERR_INCOMPLETE;
          nres    = 2'd1;
        end
      end
      if (nres == 2'd0) begin
        r0.kind = KIND_DONE;
        nres    = 2'd1;
      end else begin
        r1.kind = KIND_DONE;
        nres    = 2'd2;
      end
      ps_nxt     = ST_IDLE;
      rs_nxt     = ST_IDLE;
      meq_nxt    = 1'b0;
      tne_nxt    = 1'b0;
      halted_nxt = 1'b0;
    end else if (!halted_r && in_byte != CH_CR) begin
      case (ps_r)
        ST_IDLE: begin
          if (in_byte == CH_EQUALS || in_byte == CH_DASH) begin
            meq_nxt = (in_byte == CH_EQUALS);
            ps_nxt  = ST_BEFORE;
          end else if (!ws) begin
            r0.data = in_byte;
            nres    = 2'd1;
            tne_nxt = 1'b1;
            ps_nxt  = ST_KEY;
          end
        end
        ST_BEFORE: begin
          if (ws) begin
            r0.kind    = KIND_ERROR;
            r0.err     = ERR_BLANK_BEFORE;
            nres       = 2'd1;
            halted_nxt = 1'b1;
          end else if (in_byte != mark) begin
            r0.data = in_byte;
            nres    = 2'd1;
            tne_nxt = 1'b1;
            ps_nxt  = ST_TITLE;
          end
        end
        ST_TITLE: begin
          if (in_byte == CH_LF) begin
            rs_nxt = ST_TITLE;
            ps_nxt = ST_NEWLINE;
          end else if (ws) begin
            rs_nxt = ST_TITLE;
            ps_nxt = ST_SPACE;
          end else if (in_byte == mark) begin
            ps_nxt = ST_AFTER;
          end else begin
            r0.data = in_byte;
            nres    = 2'd1;
            tne_nxt = 1'b1;
          end
        end
        ST_AFTER: begin
          if (in_byte == CH_LF) begin
            r0.kind = KIND_END;
            r0.tok  = meq_r ? TOK_TITLE0 : TOK_TITLE1;
            nres    = 2'd1;
            tne_nxt = 1'b0;
            rs_nxt  = ST_IDLE;
            ps_nxt  = ST_IDLE;
          end else if (in_byte != mark) begin
            r0.kind    = KIND_ERROR;
            r0.err     = ERR_BAD_AFTER;
            nres       = 2'd1;
            halted_nxt = 1'b1;
          end
        end
        ST_KEY, ST_VALUE: begin
          if (ps_r == ST_KEY && in_byte == CH_COLON) begin
            r0.kind = KIND_END;
            r0.tok  = TOK_KEY;
            nres    = 2'd1;
            tne_nxt = 1'b0;
            rs_nxt  = ST_IDLE;
            ps_nxt  = ST_VALUE;
          end else if (in_byte == CH_LF) begin
            rs_nxt = ps_r;
            ps_nxt = ST_NEWLINE;
          end else if (ws) begin
            rs_nxt = ps_r;
            ps_nxt = ST_SPACE;
          end else begin
            r0.data = in_byte;
            nres    = 2'd1;
            tne_nxt = 1'b1;
          end
        end
        ST_NEWLINE, ST_SPACE: begin
          if (in_byte == CH_LF) begin
            if (ps_r == ST_SPACE) begin
              ps_nxt = ST_NEWLINE;
            end else if (rs_r != ST_VALUE) begin
              r0.kind    = KIND_ERROR;
              r0.err     = ERR_BLANK_LINE;
              nres       = 2'd1;
              halted_nxt = 1'b1;
            end else begin
              r0.kind = KIND_END;
              r0.tok  = TOK_VALUE;
              nres    = 2'd1;
              tne_nxt = 1'b0;
              rs_nxt  = ST_IDLE;
              ps_nxt  = ST_IDLE;
            end
          end else if (!ws) begin
            // fold the whitespace run to one space inside a token
            if (tne_r) begin
              r0.data = CH_SPACE;
              r1.data = in_byte;
              nres    = 2'd2;
            end else begin
              r0.data = in_byte;
              nres    = 2'd1;
            end
            tne_nxt = 1'b1;
            ps_nxt  = rs_r;
          end
        end
        default: begin
          ps_nxt = ST_IDLE;
        end
      endcase
    end
  end

  assign push            = acc && (nres != 2'd0);
  assign push_entry.two  = (nres == 2'd2);
  assign push_entry.res0 = r0;
  assign push_entry.res1 = r1;

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r     <= ST_IDLE;
      rs_r     <= ST_IDLE;
      meq_r    <= 1'b0;
      tne_r    <= 1'b0;
      halted_r <= 1'b0;
    end else if (acc) begin
      ps_r     <= ps_nxt;
      rs_r     <= rs_nxt;
      meq_r    <= meq_nxt;
      tne_r    <= tne_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Once halted, data bytes produce nothing
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc && halted_r && in_command == CMD_DATA |-> !push)
    else $error("halted parser produced a result");

  // End of stream returns the parser to its reset state
  a_eos_reset: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_command == CMD_EOS |=> ps_r == ST_IDLE && !halted_r && !tne_r)
    else $error("end of stream did not reset parser");

  // Stream-ended marker is always the final result of an entry
  a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.two |-> push_entry.res0.kind != KIND_DONE)
    else $error("stream-ended marker not last");

endmodule

// File: src/stt_queue.sv
// Small FIFO of result entries between the parser and the output stage.
// Uses stt_pkg for the entry type.
`timescale 1ns / 1ps

module stt_queue
  import stt_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   q_ready,
  input  logic   pop,
  output logic   q_valid,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign q_ready = (cnt_r != CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign head    = mem_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: src/stt_back.sv
// Output stage: drains queue entries one result per cycle, unless stalled, into a
// registered valid/ready port and marks the last result of each entry. Uses stt_pkg.
`timescale 1ns / 1ps

module stt_back
  import stt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  entry_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_token_kind,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  logic       out_valid_r;
  logic       sel_r;
  result_t    res_r;
  logic       last_r;
  logic       load;
  logic       is_last;
  result_t    cur;

  assign load    = q_valid && (!out_valid_r || out_ready);
  assign cur     = sel_r ? head.res1 : head.res0;
  assign is_last = sel_r || !head.two;
  assign pop     = load && is_last;

  // Output register and second-result select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      sel_r       <= !is_last;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_byte       = res_r.data;
  assign out_token_kind = res_r.tok;
  assign out_error_code = res_r.err;
  assign out_last       = last_r;

endmodule

// File: src/session_text_tokenizer_core.sv
// Session text tokenizer, top level: parser front end, entry queue,
// output stage. Accepts one byte per cycle when the queue has room.
// Each result is stored in the entry queue, then in the output register.
// Throughput: one input item per cycle while the queue has room, one result
// per cycle out unless stalled; two-result items are absorbed by the queue.
// Reset (rst_n low, synchronous) returns the parser to idle and empties all.
`timescale 1ns / 1ps

module session_text_tokenizer_core
  import stt_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] out_token_kind,
  output logic [1:0] out_error_code,
  output logic       out_last
);

  logic   q_ready, q_valid, push, pop;
  entry_t push_entry, head;

  stt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_byte    (in_byte),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  stt_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .head       (head)
  );

  stt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_token_kind (out_token_kind),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule
